FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sieve bitmap RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that two commands never fire in the same cycle.
`define ASSERT_EXCL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !((a) && (b))) else $error(msg);

`endif

FILE: rtl/psb_pkg.sv
// ---------------------------------------------------------------------------
// psb_pkg
// Types and codes shared by the sieve bitmap controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package psb_pkg;

  // Operation codes carried by the operation field of an input word.
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PRIME_RD,
    ST_PRIME_CHK,
    ST_CLEAR,
    ST_RESP
  } psb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_query;
    logic start_build;
    logic init_write;
    logic prime_read;
    logic prime_next;
    logic clear_start;
    logic clear_write;
    logic push_build;
  } psb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic prime_over;
    logic prime_bit;
    logic clear_last;
    logic pend;
    logic out_free;
  } psb_status_t;

endpackage

`default_nettype wire

FILE: rtl/psb_ctrl.sv
// ---------------------------------------------------------------------------
// psb_ctrl
// Sequencer for the sieve: input acceptance, init sweep, prime scan, multiple clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module psb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                operation,
  output logic                     in_ready,
  input  wire psb_pkg::psb_status_t status,
  output psb_pkg::psb_cmd_t        cmd
);
  import psb_pkg::*;

  psb_state_t state;
  psb_state_t state_next;
  logic       accept;

  // Take a word only when idle and the query pending stage can drain.
  assign in_ready = (state == ST_IDLE) && (!status.pend || status.out_free);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_BUILD)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        if (status.init_last) begin
          state_next = ST_PRIME_RD;
        end
      end
      ST_PRIME_RD: begin
        if (status.prime_over) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_PRIME_CHK;
        end
      end
      ST_PRIME_CHK: begin
        if (status.prime_bit) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_PRIME_RD;
        end
      end
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_PRIME_RD;
        end
      end
      ST_RESP: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept_query = accept && (operation == OP_QUERY);
        cmd.start_build  = accept && (operation == OP_BUILD);
      end
      ST_INIT: begin
        cmd.init_write = 1'b1;
      end
      ST_PRIME_RD: begin
        cmd.prime_read = !status.prime_over;
      end
      ST_PRIME_CHK: begin
        cmd.clear_start = status.prime_bit;
        cmd.prime_next  = !status.prime_bit;
      end
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        cmd.prime_next  = status.clear_last;
      end
      ST_RESP: begin
        cmd.push_build = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/psb_datapath.sv
// ---------------------------------------------------------------------------
// psb_datapath
// Bitmap memory, sieve counters, limit register and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psb_datapath #(
  parameter int unsigned MAX_N = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              limit_we,
  input  wire logic [15:0]       limit_wdata,
  input  wire logic [15:0]       value,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   is_prime,
  output logic                   out_of_range,
  output logic                   build_done,
  input  wire psb_pkg::psb_cmd_t cmd,
  output psb_pkg::psb_status_t   status
);
  import psb_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_N);
  localparam int unsigned SAT = ((MAX_N - 1) > 65535) ? 65535 : (MAX_N - 1);
  localparam logic [15:0] SAT_LIM = 16'(SAT);

  logic [15:0] limit;
  logic [15:0] lim_sat;
  logic        built;
  logic [15:0] built_limit;

  logic [15:0] idx;
  logic [8:0]  p;
  logic [17:0] sq;
  logic [17:0] j;
  logic [17:0] j_next;

  logic        mem [MAX_N];
  logic        we;
  logic [AW-1:0] waddr;
  logic        wdata;
  logic        re;
  logic [AW-1:0] raddr;
  logic        rdata;

  logic        pend;
  logic        pend_oor;
  logic        pend_move;
  logic        out_free;
  logic        init_bit;

  assign lim_sat = (limit > SAT_LIM) ? SAT_LIM : limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 16'hFFFF;
    end else if (limit_we) begin
      limit <= limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      built       <= 1'b0;
      built_limit <= '0;
    end else if (cmd.start_build) begin
      built       <= 1'b1;
      built_limit <= lim_sat;
    end
  end

  // Sieve counters: init index, odd candidate p with its square, multiple j.
  assign j_next = j + 18'({p, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.start_build) begin
      idx <= '0;
      p   <= 9'd3;
      sq  <= 18'd9;
    end else begin
      if (cmd.init_write) begin
        idx <= idx + 16'd1;
      end
      if (cmd.prime_next) begin
        p  <= p + 9'd2;
        sq <= sq + 18'({p, 2'b00}) + 18'd4;
      end
    end
    if (cmd.clear_start) begin
      j <= sq;
    end else if (cmd.clear_write) begin
      j <= j_next;
    end
  end

  assign init_bit = (idx == 16'd2) || ((idx > 16'd2) && idx[0]);

  assign we    = cmd.init_write || cmd.clear_write;
  assign waddr = cmd.init_write ? AW'(idx) : AW'(j);
  assign wdata = cmd.init_write ? init_bit : 1'b0;
  assign re    = cmd.accept_query || cmd.prime_read;
  assign raddr = cmd.accept_query ? AW'(value) : AW'(p);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Query pending stage: hold the range flag while the read completes.
  assign out_free  = !out_valid || out_ready;
  assign pend_move = pend && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.accept_query) begin
      pend <= 1'b1;
    end else if (pend_move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      pend_oor <= !built || (value > built_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move || cmd.push_build) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      is_prime     <= !pend_oor && rdata;
      out_of_range <= pend_oor;
      build_done   <= 1'b0;
    end else if (cmd.push_build) begin
      is_prime     <= 1'b0;
      out_of_range <= 1'b0;
      build_done   <= 1'b1;
    end
  end

  assign status.init_last  = (idx == built_limit);
  assign status.prime_over = (sq > 18'(built_limit));
  assign status.prime_bit  = rdata;
  assign status.clear_last = (j_next > 18'(built_limit));
  assign status.pend       = pend;
  assign status.out_free   = out_free;

  `ASSERT_CLK(a_pend_no_scan, clk, rst, pend |-> !cmd.prime_read, "scan read over pending query")
  `ASSERT_CLK(a_build_no_pend, clk, rst, cmd.push_build |-> !pend, "build word with query pending")
  `ASSERT_EXCL(a_one_writer, clk, rst, cmd.init_write, cmd.clear_write, "two map writers")

endmodule

`default_nettype wire

FILE: rtl/prime_sieve_bitmap.sv
// ---------------------------------------------------------------------------
// prime_sieve_bitmap
// One-bit primality map over 0..limit, filled by the Sieve of Eratosthenes.
// ---------------------------------------------------------------------------
// A build word (operation 0) fills the map up to the limit register, capped
// at MAX_N-1: first an init sweep writes 0 and 1 as composite, 2 as prime,
// odd entries as prime and even ones as composite; then each odd candidate
// p with p*p <= limit is read and checked and, if still prime, its odd
// multiples are cleared from p*p up. Once the scan finds p*p above the
// limit, the build result word (build_done = 1) is loaded into the result
// register and offered from there; a full result register holds the load
// back until it drains. The init sweep goes through the single write port
// of the bitmap memory. No clearing pass after reset is needed: every entry
// a query can reach is written by the build. A query word (operation 1) is
// one memory read: queries are taken every cycle while idle and results
// drain, each result passing through the query pending stage into the
// result register, and waiting in the pending stage while that is stalled.
// Values above the last built limit, or any query before the first build,
// return out_of_range = 1. Queries check against the limit of the last
// build, not the current register value. Write limit only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module prime_sieve_bitmap #(
  parameter int unsigned MAX_N = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // limit register write
  input  wire logic        limit_we,
  input  wire logic [15:0] limit_wdata,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [15:0] value,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_prime,
  output logic             out_of_range,
  output logic             build_done
);
  import psb_pkg::*;

  psb_cmd_t    cmd;
  psb_status_t status;

  // Sequence the build and gate acceptance.
  psb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the map, the counters and the result register.
  psb_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .limit_we     (limit_we),
    .limit_wdata  (limit_wdata),
    .value        (value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .is_prime     (is_prime),
    .out_of_range (out_of_range),
    .build_done   (build_done),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

FILE: bench/tb_prime_sieve_bitmap.sv
// ---------------------------------------------------------------------------
// tb_prime_sieve_bitmap
// Self-checking bench for the sieve bitmap: build and query words are driven
// over a valid/ready channel, and every result word is checked against a
// local sieve model. The limit register is reprogrammed between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_prime_sieve_bitmap;
  timeunit 1ns;
  timeprecision 1ps;

  import psb_pkg::*;

  localparam int unsigned MAP_SIZE  = 65536;
  localparam int unsigned WORD_GOAL = 1850;
  localparam int unsigned IDLE_PCT  = 13;

  typedef struct {
    logic        op;
    logic [15:0] num;
  } sieve_word_t;

  typedef struct {
    logic prime;
    logic oor;
    logic done;
  } verdict_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  // Block ports; the driven inputs are all known from time zero
  logic        limit_we    = 1'b0;
  logic [15:0] limit_wdata = 16'd0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        operation   = OP_BUILD;
  logic [15:0] value       = 16'd0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        is_prime;
  logic        out_of_range;
  logic        build_done;

  prime_sieve_bitmap #(
    .MAX_N(MAP_SIZE)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_prime    (is_prime),
    .out_of_range(out_of_range),
    .build_done  (build_done)
  );

  // Words waiting to be driven, and verdicts waiting to come back
  sieve_word_t word_q[$];
  verdict_t    verdict_q[$];
  int          err_count = 0;
  bit          steady    = 1'b0;  // suppress random idling on both sides

  // Local copy of the block's state and register
  bit          prime_bits[MAP_SIZE];
  bit          has_built   = 1'b0;
  logic [15:0] built_lim   = 16'd0;
  logic [15:0] limit_copy  = 16'hFFFF;

  // Refill the bitmap for 0..lim with the odd-only sieve.
  function automatic void run_sieve(input int unsigned lim);
    int unsigned i;
    int unsigned j;
    if (lim > MAP_SIZE - 1) lim = MAP_SIZE - 1;
    for (i = 0; i <= lim; i++) begin
      prime_bits[i] = (i == 2) || (i > 2 && i[0]);
    end
    for (i = 3; i * i <= lim; i += 2) begin
      if (prime_bits[i]) begin
        for (j = i * i; j <= lim; j += 2 * i) prime_bits[j] = 1'b0;
      end
    end
    has_built = 1'b1;
    built_lim = lim[15:0];
  endfunction

  // Work out the verdict for one accepted word and queue it.
  function automatic void predict_verdict(input sieve_word_t w);
    verdict_t v;
    v = '{prime: 1'b0, oor: 1'b0, done: 1'b0};
    if (w.op == OP_BUILD) begin
      run_sieve(limit_copy);
      v.done = 1'b1;
    end else if (!has_built || w.num > built_lim) begin
      v.oor = 1'b1;
    end else begin
      v.prime = prime_bits[w.num];
    end
    verdict_q.insert(verdict_q.size(), v);
  endfunction

  // Driver: hold the word until accepted, then advance to the next one,
  // dropping valid now and then.
  always @(posedge clk) begin
    logic        nxt_valid;
    logic        nxt_op;
    logic [15:0] nxt_num;
    bit          took;
    nxt_valid = in_valid;
    nxt_op    = operation;
    nxt_num   = value;
    took      = 1'b0;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_verdict(word_q.pop_front());
        took = 1'b1;
      end
      if (took || !in_valid) begin
        if (word_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt_valid = 1'b1;
          nxt_op    = word_q[0].op;
          nxt_num   = word_q[0].num;
        end else begin
          nxt_valid = 1'b0;
        end
      end
    end
    in_valid  <= nxt_valid;
    operation <= nxt_op;
    value     <= nxt_num;
  end

  // Monitor: check each result word against the oldest verdict, stall at random.
  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no verdict pending");
          err_count++;
        end else begin
          v = verdict_q.pop_front();
          if (is_prime !== v.prime) begin
            $error("is_prime: expected %0d, got %0d", v.prime, is_prime);
            err_count++;
          end
          if (out_of_range !== v.oor) begin
            $error("out_of_range: expected %0d, got %0d", v.oor, out_of_range);
            err_count++;
          end
          if (build_done !== v.done) begin
            $error("build_done: expected %0d, got %0d", v.done, build_done);
            err_count++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  int unsigned sent = 0;

  task automatic push_word(input logic op, input logic [15:0] num);
    sieve_word_t w;
    w.op  = op;
    w.num = num;
    word_q.insert(word_q.size(), w);
    sent++;
  endtask

  // Hold the sender until the block is idle and every verdict has come back.
  task automatic drain();
    while (word_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
  endtask

  // Write the limit register; only call while drained.
  task automatic write_limit(input logic [15:0] lim);
    @(posedge clk);
    limit_we    <= 1'b1;
    limit_wdata <= lim;
    limit_copy   = lim;
    @(posedge clk);
    limit_we    <= 1'b0;
  endtask

  // Run guard
  initial begin
    #400_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned gen_built;   // limit of the last build pushed so far
    int unsigned lim;
    int unsigned r;
    int unsigned k;
    bit          lead_build;
    logic [15:0] num;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Queries before any build must all come back out of range.
    push_word(OP_QUERY, 16'd0);
    push_word(OP_QUERY, 16'd2);
    push_word(OP_QUERY, 16'hFFFF);

    // Full-size build at the reset limit, then probe the edges of the map.
    push_word(OP_BUILD, 16'd0);
    push_word(OP_QUERY, 16'd0);
    push_word(OP_QUERY, 16'd1);
    push_word(OP_QUERY, 16'd2);
    push_word(OP_QUERY, 16'd3);
    push_word(OP_QUERY, 16'd4);
    push_word(OP_QUERY, 16'd9);
    push_word(OP_QUERY, 16'd25);
    push_word(OP_QUERY, 16'd65521);   // largest 16-bit prime
    push_word(OP_QUERY, 16'd65534);
    push_word(OP_QUERY, 16'hFFFF);
    drain();

    // Shrink the limit without rebuilding: queries still use the old bound.
    write_limit(16'd2);
    push_word(OP_QUERY, 16'd3);
    push_word(OP_QUERY, 16'd4093);
    // Build at limit 2: only 0 to 2 are in range, and only 2 is prime.
    push_word(OP_BUILD, 16'hFFFF);
    push_word(OP_QUERY, 16'd0);
    push_word(OP_QUERY, 16'd1);
    push_word(OP_QUERY, 16'd2);
    push_word(OP_QUERY, 16'd3);
    drain();

    write_limit(16'd3);
    push_word(OP_BUILD, 16'd0);
    push_word(OP_QUERY, 16'd3);
    push_word(OP_QUERY, 16'd4);
    gen_built = 3;

    // Random phases: new limit each phase, mostly small so builds stay short.
    phase = 0;
    while (sent < WORD_GOAL) begin
      phase++;
      drain();
      r = $urandom_range(0, 99);
      if (phase == 4)  lim = 65535;
      else if (r < 60) lim = $urandom_range(2, 200);
      else if (r < 90) lim = $urandom_range(201, 2000);
      else             lim = $urandom_range(2001, 8000);
      write_limit(lim[15:0]);
      steady     = (phase == 2);
      // Now and then skip the leading build to query against the old bound.
      lead_build = ($urandom_range(0, 3) != 0);
      for (k = 0; k < 150 && sent < WORD_GOAL; k++) begin
        r = $urandom_range(0, 99);
        if ((k == 0 && lead_build) || r < 4) begin
          push_word(OP_BUILD, 16'($urandom()));
          gen_built = lim;
        end else begin
          if (r < 75)      num = 16'($urandom_range(0, gen_built));
          else if (r < 85) num = 16'((gen_built + $urandom_range(0, 2) > 65535) ?
                                     65535 : gen_built + $urandom_range(0, 2));
          else             num = 16'($urandom());
          push_word(OP_QUERY, num);
        end
      end
    end

    drain();
    steady = 1'b0;
    repeat (16) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
